FILE: rtl/pngf_pkg.sv
package pngf_pkg;

  localparam int MAX_RESULTS = 12;
  localparam int COUNT_BITS = $clog2(MAX_RESULTS + 1);

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NO_CHUNK = 2'd1;
  localparam logic [1:0] STATUS_CHUNK_OPEN = 2'd2;

  localparam logic [7:0] TYPE_I = 8'h49;
  localparam logic [7:0] TYPE_D = 8'h44;
  localparam logic [7:0] TYPE_A = 8'h41;
  localparam logic [7:0] TYPE_T = 8'h54;

  // reflected CRC-32, one byte
  function automatic logic [31:0] crc_add(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // running CRC after the four type bytes, not yet inverted
  localparam logic [31:0] CRC_AFTER_TYPE =
    crc_add(crc_add(crc_add(crc_add(CRC_INIT, TYPE_I), TYPE_D), TYPE_A), TYPE_T);

  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [COUNT_BITS-1:0]       count;
    logic                        done;
    logic [1:0]                  status;
  } burst_t;

endpackage

FILE: rtl/pngf_burst.sv
module pngf_burst (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  pngf_pkg::burst_t burst,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             out_done,
  output logic [1:0]       out_status
);

  logic [pngf_pkg::MAX_RESULTS-1:0][7:0] bytes;
  logic [pngf_pkg::COUNT_BITS-1:0]       remaining;
  logic                                  done;
  logic [1:0]                            status;
  logic                                  last;

  assign last       = (remaining == pngf_pkg::COUNT_BITS'(1));
  assign out_valid  = (remaining != '0);
  assign can_load   = (remaining == '0) || (last && out_ready);
  assign out_byte   = bytes[0];
  assign out_last   = last;
  assign out_done   = done && last;
  assign out_status = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (load) begin
      remaining <= burst.count;
    end else if (out_valid && out_ready) begin
      remaining <= remaining - pngf_pkg::COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes  <= burst.bytes;
      done   <= burst.done;
      status <= burst.status;
    end else if (out_valid && out_ready) begin
      // advance to the next byte of the burst
      bytes <= bytes >> 8;
    end
  end

endmodule

FILE: rtl/png_idat_chunk_framer_crc32_top.sv
// The first output byte of a request is valid in the cycle after it is accepted.
// A data byte yields one output byte (five when it closes the chunk); a start yields
// eight, twelve for a zero-length chunk and one while a chunk is open. A new request
// is taken in the cycle the last byte of the previous one leaves.
// Reset (rst, synchronous, active high) closes any chunk, clears the byte count,
// sets the CRC to all ones and drops any pending output.
module png_idat_chunk_framer_crc32_top #(
  parameter int LENGTH_BITS = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // chunk_length[30:0], data_byte[38:31], zero pad
  input  logic        s_tuser,  // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // out_byte[7:0]
  output logic        m_tlast,  // run_last
  output logic [2:0]  m_tuser   // chunk_done[0], status[2:1]
);

  logic [LENGTH_BITS-1:0] bytes_left;
  logic [LENGTH_BITS-1:0] bytes_left_next;
  logic [31:0]            crc_accum;
  logic [31:0]            crc_accum_next;
  logic                   chunk_open;
  logic                   chunk_open_next;

  logic                   accept;
  logic                   command;
  logic [LENGTH_BITS-1:0] len;
  logic [31:0]            len32;
  logic [7:0]             data_byte;
  logic [31:0]            crc_data;
  logic [31:0]            crc_out;
  logic [LENGTH_BITS-1:0] left_dec;
  pngf_pkg::burst_t       burst;
  logic                   out_done;
  logic [1:0]             out_status;

  assign command   = s_tuser;
  assign len       = s_tdata[LENGTH_BITS-1:0];
  assign len32     = 32'(len);
  assign data_byte = s_tdata[38:31];
  assign accept    = s_tvalid && s_tready;

  assign crc_data = pngf_pkg::crc_add(crc_accum, data_byte);
  assign left_dec = bytes_left - LENGTH_BITS'(1);

  always_comb begin
    burst           = '0;
    bytes_left_next = bytes_left;
    crc_accum_next  = crc_accum;
    chunk_open_next = chunk_open;
    crc_out         = '0;
    if (command == pngf_pkg::CMD_START) begin
      if (chunk_open) begin
        burst.count  = pngf_pkg::COUNT_BITS'(1);
        burst.status = pngf_pkg::STATUS_CHUNK_OPEN;
      end else begin
        crc_out        = ~pngf_pkg::CRC_AFTER_TYPE;
        burst.bytes[0] = len32[31:24];
        burst.bytes[1] = len32[23:16];
        burst.bytes[2] = len32[15:8];
        burst.bytes[3] = len32[7:0];
        burst.bytes[4] = pngf_pkg::TYPE_I;
        burst.bytes[5] = pngf_pkg::TYPE_D;
        burst.bytes[6] = pngf_pkg::TYPE_A;
        burst.bytes[7] = pngf_pkg::TYPE_T;
        burst.status   = pngf_pkg::STATUS_OK;
        if (len == '0) begin
          // empty chunk: close at once with the CRC of the type alone
          burst.bytes[8]  = crc_out[31:24];
          burst.bytes[9]  = crc_out[23:16];
          burst.bytes[10] = crc_out[15:8];
          burst.bytes[11] = crc_out[7:0];
          burst.count     = pngf_pkg::COUNT_BITS'(12);
          burst.done      = 1'b1;
          crc_accum_next  = pngf_pkg::CRC_INIT;
          bytes_left_next = '0;
        end else begin
          burst.count     = pngf_pkg::COUNT_BITS'(8);
          crc_accum_next  = pngf_pkg::CRC_AFTER_TYPE;
          bytes_left_next = len;
          chunk_open_next = 1'b1;
        end
      end
    end else begin
      if (!chunk_open) begin
        burst.count  = pngf_pkg::COUNT_BITS'(1);
        burst.status = pngf_pkg::STATUS_NO_CHUNK;
      end else begin
        crc_out        = ~crc_data;
        burst.bytes[0] = data_byte;
        burst.status   = pngf_pkg::STATUS_OK;
        if (left_dec == '0) begin
          burst.bytes[1]  = crc_out[31:24];
          burst.bytes[2]  = crc_out[23:16];
          burst.bytes[3]  = crc_out[15:8];
          burst.bytes[4]  = crc_out[7:0];
          burst.count     = pngf_pkg::COUNT_BITS'(5);
          burst.done      = 1'b1;
          crc_accum_next  = pngf_pkg::CRC_INIT;
          bytes_left_next = '0;
          chunk_open_next = 1'b0;
        end else begin
          burst.count     = pngf_pkg::COUNT_BITS'(1);
          crc_accum_next  = crc_data;
          bytes_left_next = left_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= '0;
      crc_accum  <= pngf_pkg::CRC_INIT;
      chunk_open <= 1'b0;
    end else if (accept) begin
      bytes_left <= bytes_left_next;
      crc_accum  <= crc_accum_next;
      chunk_open <= chunk_open_next;
    end
  end

  pngf_burst u_burst (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .burst      (burst),
    .can_load   (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast),
    .out_done   (out_done),
    .out_status (out_status)
  );

  assign m_tuser = {out_status, out_done};

endmodule

FILE: test/tb_top.sv
module tb_top;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_ITEMS = 220;
  localparam int CALM_ITEMS = 40;
  localparam logic [7:0] IDAT_TYPE [4] =
    '{pngf_pkg::TYPE_I, pngf_pkg::TYPE_D, pngf_pkg::TYPE_A, pngf_pkg::TYPE_T};

  typedef struct packed {
    logic        cmd;
    logic [30:0] len;
    logic [7:0]  dbyte;
  } request_t;

  typedef struct packed {
    logic [7:0] obyte;
    logic       last;
    logic       done;
    logic [1:0] status;
  } framed_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // chunk_length[30:0], data_byte[38:31], zero pad
  logic        s_tuser = 1'b0;  // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;  // out_byte[7:0]
  logic        m_tlast;  // run_last
  logic [2:0]  m_tuser;  // chunk_done[0], status[2:1]

  png_idat_chunk_framer_crc32_top #(
    .LENGTH_BITS(31)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  request_t     request_q[$];
  framed_byte_t framed_q[$];
  int           fail_cnt = 0;

  // framer state as the block should hold it
  logic         in_chunk = 1'b0;
  logic [30:0]  bytes_rem = '0;
  logic [31:0]  crc_run = pngf_pkg::CRC_INIT;

  function automatic logic [31:0] crc32_step(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ 32'hEDB88320;
      else c = c >> 1;
    end
    return c;
  endfunction

  task automatic emit(input logic [7:0] b, input logic d, input logic [1:0] st);
    framed_byte_t o;
    o.obyte = b;
    o.last = 1'b0;
    o.done = d;
    o.status = st;
    framed_q.push_back(o);
  endtask

  task automatic emit_crc();
    logic [31:0] c;
    c = ~crc_run;
    emit(c[31:24], 1'b0, pngf_pkg::STATUS_OK);
    emit(c[23:16], 1'b0, pngf_pkg::STATUS_OK);
    emit(c[15:8], 1'b0, pngf_pkg::STATUS_OK);
    emit(c[7:0], 1'b1, pngf_pkg::STATUS_OK);
    crc_run = pngf_pkg::CRC_INIT;
    bytes_rem = '0;
    in_chunk = 1'b0;
  endtask

  task automatic frame_request(input request_t r);
    framed_byte_t o;
    if (r.cmd == pngf_pkg::CMD_START) begin
      if (in_chunk) begin
        emit(8'h00, 1'b0, pngf_pkg::STATUS_CHUNK_OPEN);
      end else begin
        emit({1'b0, r.len[30:24]}, 1'b0, pngf_pkg::STATUS_OK);
        emit(r.len[23:16], 1'b0, pngf_pkg::STATUS_OK);
        emit(r.len[15:8], 1'b0, pngf_pkg::STATUS_OK);
        emit(r.len[7:0], 1'b0, pngf_pkg::STATUS_OK);
        crc_run = pngf_pkg::CRC_INIT;
        for (int i = 0; i < 4; i++) begin
          emit(IDAT_TYPE[i], 1'b0, pngf_pkg::STATUS_OK);
          crc_run = crc32_step(crc_run, IDAT_TYPE[i]);
        end
        if (r.len == '0) begin
          emit_crc();
        end else begin
          bytes_rem = r.len;
          in_chunk = 1'b1;
        end
      end
    end else begin
      if (!in_chunk) begin
        emit(8'h00, 1'b0, pngf_pkg::STATUS_NO_CHUNK);
      end else begin
        emit(r.dbyte, 1'b0, pngf_pkg::STATUS_OK);
        crc_run = crc32_step(crc_run, r.dbyte);
        bytes_rem = bytes_rem - 31'd1;
        if (bytes_rem == '0) emit_crc();
      end
    end
    // mark the last byte of this request
    o = framed_q.pop_back();
    o.last = 1'b1;
    framed_q.push_back(o);
  endtask

  task automatic queue_req(input logic cmd, input logic [30:0] len, input logic [7:0] b);
    request_t r;
    r.cmd = cmd;
    r.len = len;
    r.dbyte = b;
    request_q.push_back(r);
  endtask

  // well-formed chunk with random payload, now and then a stray start inside it
  task automatic queue_chunk(input int n);
    queue_req(pngf_pkg::CMD_START, 31'(n), 8'($urandom));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 29) == 0)
        queue_req(pngf_pkg::CMD_START, 31'($urandom), 8'($urandom));
      queue_req(pngf_pkg::CMD_DATA, 31'($urandom), 8'($urandom));
    end
  endtask

  // driver
  logic drv_valid;
  int   src_gap = 0;

  always @(posedge clk) begin
    if (!rst) begin
      drv_valid = s_tvalid;
      if (s_tvalid && s_tready) begin
        frame_request(request_q.pop_front());
        drv_valid = 1'b0;
        if (request_q.size() > CALM_ITEMS && $urandom_range(0, 4) == 0)
          src_gap = $urandom_range(1, 10);
      end
      if (!drv_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (request_q.size() > 0) begin
          drv_valid = 1'b1;
          s_tuser <= request_q[0].cmd;
          s_tdata <= {1'b0, request_q[0].dbyte, request_q[0].len};
        end
      end
      s_tvalid <= drv_valid;
    end
  end

  // monitor
  framed_byte_t want;
  logic rdy;
  int   snk_gap = 0;
  int   hold_left = 0;
  int   seen = 0;
  bit   held = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        seen++;
        if (framed_q.size() == 0) begin
          $error("unexpected output byte %h", m_tdata);
          fail_cnt++;
        end else begin
          want = framed_q.pop_front();
          if (m_tdata !== want.obyte) begin
            $error("out_byte: expected %h, got %h", want.obyte, m_tdata);
            fail_cnt++;
          end
          if (m_tlast !== want.last) begin
            $error("run_last: expected %b, got %b", want.last, m_tlast);
            fail_cnt++;
          end
          if (m_tuser[0] !== want.done) begin
            $error("chunk_done: expected %b, got %b", want.done, m_tuser[0]);
            fail_cnt++;
          end
          if (m_tuser[2:1] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser[2:1]);
            fail_cnt++;
          end
        end
      end
      // hold off once for a long stretch so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!held && seen >= 40) begin
        held = 1'b1;
        hold_left = 400;
        rdy = 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (request_q.size() > CALM_ITEMS && $urandom_range(0, 5) == 0)
          snk_gap = $urandom_range(1, 10);
      end
      m_tready <= rdy;
    end
  end

  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  int base;
  int r;

  initial begin
    // directed: errors with no chunk, zero-length chunk, start while open, byte extremes
    queue_req(pngf_pkg::CMD_DATA, 31'h7FFFFFFF, 8'hFF);
    queue_req(pngf_pkg::CMD_DATA, 31'h0, 8'h00);
    queue_req(pngf_pkg::CMD_START, 31'h0, 8'hFF);
    queue_req(pngf_pkg::CMD_START, 31'd1, 8'h00);
    queue_req(pngf_pkg::CMD_START, 31'd5, 8'h5A);
    queue_req(pngf_pkg::CMD_DATA, 31'h7FFFFFFF, 8'h00);
    queue_req(pngf_pkg::CMD_START, 31'd3, 8'h00);
    queue_req(pngf_pkg::CMD_DATA, 31'h0, 8'hFF);
    queue_req(pngf_pkg::CMD_DATA, 31'h0, 8'h80);
    queue_req(pngf_pkg::CMD_DATA, 31'h0, 8'h01);
    queue_req(pngf_pkg::CMD_DATA, 31'h0, 8'h55);
    queue_req(pngf_pkg::CMD_START, 31'd2, 8'h00);
    queue_req(pngf_pkg::CMD_DATA, 31'h2AAAAAAA, 8'h55);
    queue_req(pngf_pkg::CMD_DATA, 31'h55555555, 8'hAA);
    queue_req(pngf_pkg::CMD_START, 31'h0, 8'h00);

    // random: mostly whole chunks, some stray bytes and empty chunks
    base = request_q.size();
    while (request_q.size() < base + RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      if (r == 0) queue_req(pngf_pkg::CMD_DATA, 31'($urandom), 8'($urandom));
      else if (r == 1) queue_req(pngf_pkg::CMD_START, 31'h0, 8'($urandom));
      else if (r == 2) queue_chunk($urandom_range(13, 40));
      else queue_chunk($urandom_range(1, 12));
    end

    // largest length last: this chunk never closes
    queue_req(pngf_pkg::CMD_START, 31'h7FFFFFFF, 8'($urandom));
    for (int i = 0; i < 6; i++) queue_req(pngf_pkg::CMD_DATA, 31'($urandom), 8'($urandom));
    queue_req(pngf_pkg::CMD_START, 31'h0, 8'($urandom));
    queue_req(pngf_pkg::CMD_DATA, 31'($urandom), 8'hFF);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() > 0 || s_tvalid) @(posedge clk);
    while (framed_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
